// File: rtl/core/assert_macros.svh
// Assertion macros shared by the statement counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OSC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define OSC_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define OSC_ASSERT(lbl, prop, msg)
`define OSC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

// File: rtl/core/osc_pkg.sv
// Shared types, constants and keyword matcher for the statement counter.
`default_nettype none
package osc_pkg;

   localparam int COUNT_W = 20;
   localparam int NUM_CNT = 9;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1000000);

   localparam int RSP_BITS    = 1 + NUM_CNT * COUNT_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int C_POS  = 0;
   localparam int C_TEX  = 1;
   localparam int C_NRM  = 2;
   localparam int C_FACE = 3;
   localparam int C_TRI  = 4;
   localparam int C_GRP  = 5;
   localparam int C_MUSE = 6;
   localparam int C_MLIB = 7;
   localparam int C_IGN  = 8;

   localparam logic [1:0] NEED_POS  = 2'd3;
   localparam logic [1:0] NEED_TEX  = 2'd2;
   localparam logic [1:0] NEED_NRM  = 2'd3;
   localparam logic [1:0] NEED_NAME = 2'd1;
   localparam logic [1:0] OPS_MAX   = 2'd3;
   localparam logic [COUNT_W-1:0] FACE_MIN = COUNT_W'(3);
   localparam logic [COUNT_W-1:0] FACE_TRI_OFS = COUNT_W'(2);

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BSL   = 8'h5C;

   typedef enum logic [4:0] {
      KW_NONE   = 5'd0,
      KW_V      = 5'd1,
      KW_VT     = 5'd2,
      KW_VN     = 5'd3,
      KW_F      = 5'd4,
      KW_G      = 5'd5,
      KW_U      = 5'd6,
      KW_US     = 5'd7,
      KW_USE    = 5'd8,
      KW_USEM   = 5'd9,
      KW_USEMT  = 5'd10,
      KW_USEMTL = 5'd11,
      KW_M      = 5'd12,
      KW_MT     = 5'd13,
      KW_MTL    = 5'd14,
      KW_MTLL   = 5'd15,
      KW_MTLLI  = 5'd16,
      KW_MTLLIB = 5'd17,
      KW_OTHER  = 5'd18
   } kw_type;

   typedef struct packed {
      logic               close;
      logic               fault;
      kw_type             kw;
      logic [1:0]         ops;
      logic [COUNT_W-1:0] fv;
   } line_ev_type;

   typedef struct packed {
      logic [NUM_CNT-1:0][COUNT_W-1:0] counts;
      logic                            ok;
   } rsp_type;

   function automatic kw_type kw_next(input kw_type k, input logic [7:0] c);
      kw_type r;
      r = KW_OTHER;
      case (k)
         KW_NONE: begin
            if (c == "v") r = KW_V;
            else if (c == "f") r = KW_F;
            else if (c == "g") r = KW_G;
            else if (c == "u") r = KW_U;
            else if (c == "m") r = KW_M;
         end
         KW_V: begin
            if (c == "t") r = KW_VT;
            else if (c == "n") r = KW_VN;
         end
         KW_U:     if (c == "s") r = KW_US;
         KW_US:    if (c == "e") r = KW_USE;
         KW_USE:   if (c == "m") r = KW_USEM;
         KW_USEM:  if (c == "t") r = KW_USEMT;
         KW_USEMT: if (c == "l") r = KW_USEMTL;
         KW_M:     if (c == "t") r = KW_MT;
         KW_MT:    if (c == "l") r = KW_MTL;
         KW_MTL:   if (c == "l") r = KW_MTLL;
         KW_MTLL:  if (c == "i") r = KW_MTLLI;
         KW_MTLLI: if (c == "b") r = KW_MTLLIB;
         default:  r = KW_OTHER;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/obj_statement_counter_top.sv
// Result: the item built when the last input item is accepted is registered, then appears on rsp_.
// Throughput: one input byte per cycle while req_tready is high; each byte updates the line state and
//   at most one counter (or face and triangle together); the two-entry result buffer drops ready when full.
// Reset: synchronous, active high; clears line state, counters and error, sets the
//   count limit to 1000000 and empties the result buffer.
`default_nettype none
module obj_statement_counter_top
   import osc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,  // [7:0] data_byte
   input  wire logic                   req_tuser,  // [0] has_byte
   input  wire logic                   req_tlast,  // last
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] ok, [20:1] position_count, [40:21] texcoord_count, [60:41] normal_count,
   // [80:61] face_count, [100:81] triangle_count, [120:101] group_count,
   // [140:121] material_use_count, [160:141] material_library_count,
   // [180:161] ignored_count, [183:181] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_wr_en,
   input  wire logic [COUNT_W-1:0]     csr_wr_data
);

   logic               accept, push, ready;
   logic [COUNT_W-1:0] limit;
   line_ev_type        ev;
   rsp_type            item;

   assign req_tready = ready;
   assign accept     = req_tvalid && ready;

   osc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .en        (accept),
      .data_byte (req_tdata),
      .has_byte  (req_tuser),
      .last      (req_tlast),
      .limit     (limit),
      .ev        (ev)
   );

   osc_tally u_tally (
      .clock       (clock),
      .reset       (reset),
      .en          (accept),
      .last        (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ev          (ev),
      .limit       (limit),
      .push        (push),
      .item        (item)
   );

   osc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .item       (item),
      .ready      (ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

// File: rtl/core/osc_scan.sv
// Line and token scanner: tracks the current line and reports each closed line.
`default_nettype none
module osc_scan
   import osc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic [7:0]         data_byte,
   input  wire logic               has_byte,
   input  wire logic               last,
   input  wire logic [COUNT_W-1:0] limit,
   output line_ev_type             ev
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_LEAD_CR, PH_COMMENT, PH_DIR_GAP, PH_DIR_TOK, PH_ARG_GAP, PH_ARG_TOK
   } phase_type;

   phase_type          phase_ff, phase_in, p1;
   kw_type             kw_ff, kw1;
   logic [1:0]         ops_ff, ops1;
   logic               bad_ff, bad1, slash_ff, slash1;
   logic [COUNT_W-1:0] fv_ff, fv1;
   logic               is_lf, is_ws, is_gap, is_slash, is_bsl;
   logic               proc, line_end, start, tok_byte_end, tok_end, arg_end, fault;

   always_comb begin
      is_lf    = (data_byte == CH_LF);
      is_ws    = (data_byte == CH_SP) || (data_byte == CH_TAB) || (data_byte == CH_CR);
      is_gap   = is_ws || (data_byte == CH_VT) || (data_byte == CH_FF);
      is_slash = (data_byte == CH_SLASH);
      is_bsl   = (data_byte == CH_BSL);
      proc     = en && has_byte && !is_lf;
      line_end = en && ((has_byte && is_lf) || last);

      p1           = phase_ff;
      kw1          = kw_ff;
      bad1         = bad_ff;
      slash1       = slash_ff;
      start        = 1'b0;
      tok_byte_end = 1'b0;
      if (proc) begin
         case (phase_ff)
            PH_LEAD: begin
               if ((data_byte == CH_SP) || (data_byte == CH_TAB)) begin
                  p1 = PH_LEAD;
               end else if (data_byte == CH_CR) begin
                  p1 = PH_LEAD_CR;
               end else if (data_byte == CH_HASH) begin
                  p1 = PH_COMMENT;
               end else begin
                  p1    = PH_DIR_GAP;
                  start = !is_gap;
               end
            end
            PH_LEAD_CR: begin
               p1    = PH_DIR_GAP;
               start = !is_gap;
            end
            PH_DIR_GAP, PH_ARG_GAP: start = !is_gap;
            PH_DIR_TOK: begin
               if (is_ws) tok_byte_end = 1'b1;
               else kw1 = kw_next(kw_ff, data_byte);
            end
            PH_ARG_TOK: begin
               if (is_ws) begin
                  tok_byte_end = 1'b1;
               end else begin
                  bad1   = bad_ff || is_bsl || (data_byte == CH_VT) || (data_byte == CH_FF);
                  slash1 = is_slash;
               end
            end
            default: p1 = phase_ff;
         endcase
      end
      if (start) begin
         if (phase_ff == PH_ARG_GAP) begin
            p1     = PH_ARG_TOK;
            bad1   = is_slash || is_bsl;
            slash1 = is_slash;
         end else begin
            p1  = PH_DIR_TOK;
            kw1 = kw_next(kw_ff, data_byte);
         end
      end

      tok_end = tok_byte_end || (line_end && ((p1 == PH_DIR_TOK) || (p1 == PH_ARG_TOK)));
      arg_end = tok_end && (p1 == PH_ARG_TOK);
      ops1    = (arg_end && (ops_ff != OPS_MAX)) ? ops_ff + 2'd1 : ops_ff;
      fv1     = fv_ff;
      fault   = 1'b0;
      if (arg_end && (kw1 == KW_F)) begin
         if (bad1 || slash1) fault = 1'b1;
         else if (fv_ff >= limit) fault = 1'b1;
         else fv1 = fv_ff + COUNT_W'(1);
      end

      ev.close = line_end && (p1 != PH_LEAD) && (p1 != PH_LEAD_CR) && (p1 != PH_COMMENT);
      ev.fault = fault;
      ev.kw    = kw1;
      ev.ops   = ops1;
      ev.fv    = fv1;

      if (line_end) phase_in = PH_LEAD;
      else if (tok_byte_end) phase_in = PH_ARG_GAP;
      else phase_in = p1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         kw_ff    <= KW_NONE;
         ops_ff   <= '0;
         bad_ff   <= 1'b0;
         slash_ff <= 1'b0;
         fv_ff    <= '0;
      end else if (en) begin
         phase_ff <= phase_in;
         if (line_end) begin
            kw_ff    <= KW_NONE;
            ops_ff   <= '0;
            bad_ff   <= 1'b0;
            slash_ff <= 1'b0;
            fv_ff    <= '0;
         end else begin
            kw_ff    <= kw1;
            ops_ff   <= ops1;
            bad_ff   <= bad1;
            slash_ff <= slash1;
            fv_ff    <= fv1;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/osc_tally.sv
// Statement counters, limit register and sticky error; builds the result item.
`default_nettype none
module osc_tally
   import osc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               last,
   input  wire logic               csr_wr_en,
   input  wire logic [COUNT_W-1:0] csr_wr_data,
   input  wire line_ev_type        ev,
   output logic [COUNT_W-1:0]      limit,
   output logic                    push,
   output rsp_type                 item
);

   logic [NUM_CNT-1:0][COUNT_W-1:0] cnt_ff, cnt_in;
   logic                            err_ff, err_in;
   logic [COUNT_W-1:0]              limit_ff;
   logic [NUM_CNT-1:0]              inc;
   logic                            tri_en, bad;
   logic [COUNT_W:0]                sum, tri_sum;

   assign limit = limit_ff;

   always_comb begin
      inc    = '0;
      tri_en = 1'b0;
      bad    = 1'b0;
      if (ev.close) begin
         case (ev.kw)
            KW_V:      if (ev.ops < NEED_POS) bad = 1'b1; else inc[C_POS] = 1'b1;
            KW_VT:     if (ev.ops < NEED_TEX) bad = 1'b1; else inc[C_TEX] = 1'b1;
            KW_VN:     if (ev.ops < NEED_NRM) bad = 1'b1; else inc[C_NRM] = 1'b1;
            KW_G:      if (ev.ops < NEED_NAME) bad = 1'b1; else inc[C_GRP] = 1'b1;
            KW_USEMTL: if (ev.ops < NEED_NAME) bad = 1'b1; else inc[C_MUSE] = 1'b1;
            KW_MTLLIB: if (ev.ops < NEED_NAME) bad = 1'b1; else inc[C_MLIB] = 1'b1;
            KW_F: begin
               if (ev.fv < FACE_MIN) begin
                  bad = 1'b1;
               end else begin
                  inc[C_FACE] = 1'b1;
                  tri_en      = 1'b1;
               end
            end
            default: inc[C_IGN] = 1'b1;
         endcase
      end

      cnt_in = cnt_ff;
      for (int i = 0; i < NUM_CNT; i++) begin
         sum = {1'b0, cnt_ff[i]} + (COUNT_W+1)'(1);
         if (inc[i]) begin
            if (sum > {1'b0, limit_ff}) bad = 1'b1;
            else cnt_in[i] = sum[COUNT_W-1:0];
         end
      end
      tri_sum = {1'b0, cnt_ff[C_TRI]} + {1'b0, ev.fv - FACE_TRI_OFS};
      if (tri_en) begin
         if (tri_sum > {1'b0, limit_ff}) bad = 1'b1;
         else cnt_in[C_TRI] = tri_sum[COUNT_W-1:0];
      end

      err_in      = err_ff || ev.fault || bad;
      push        = en && last;
      item.ok     = !err_in;
      item.counts = err_in ? '0 : cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         err_ff   <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (en) begin
            if (last) begin
               cnt_ff <= '0;
               err_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_in;
               err_ff <= err_in;
            end
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/osc_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
`default_nettype none
`include "assert_macros.svh"
module osc_out_buf
   import osc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire rsp_type                item,
   output logic                        ready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   rsp_type m_ff, s_ff;
   logic    m_valid_ff, s_valid_ff;
   logic    pop;

   assign ready      = !s_valid_ff;
   assign pop        = m_valid_ff && rsp_tready;
   assign rsp_tvalid = m_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_BITS){1'b0}}, m_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (s_valid_ff) begin
         if (pop) begin
            m_ff       <= s_ff;
            s_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!m_valid_ff || pop) begin
            m_ff       <= item;
            m_valid_ff <= 1'b1;
         end else begin
            s_ff       <= item;
            s_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         m_valid_ff <= 1'b0;
      end
   end

   `OSC_ASSERT_NR(a_skid_needs_main, s_valid_ff |-> m_valid_ff, "skid item without main item")
   `OSC_ASSERT(a_no_push_when_full, push |-> !s_valid_ff, "item pushed into full buffer")
   `OSC_ASSERT(a_skid_drains, (s_valid_ff && rsp_tready) |=> !s_valid_ff, "skid item not moved")

endmodule
`default_nettype wire
